[sv/cks_pkg.sv]
// ----------------------------------------------------------------------------
// cks_pkg: shared types and constants of the composite key row sorter
// Row layout, status codes and controller/datapath command and status.
// ----------------------------------------------------------------------------
package cks_pkg;

   localparam int MaxRows      = 1024;
   localparam int MaxGroupKeys = 4;
   localparam int KeyFields    = 4;
   localparam int AddrWidth    = $clog2(MaxRows);
   localparam int CountWidth   = $clog2(MaxRows + 1);
   localparam int UsedWidth    = 3;

   localparam logic [1:0] StatusPushOk   = 2'd0;
   localparam logic [1:0] StatusPushRej  = 2'd1;
   localparam logic [1:0] StatusPopped   = 2'd2;
   localparam logic [1:0] StatusPopEmpty = 2'd3;

   localparam logic OpPush = 1'b0;
   localparam logic OpPop  = 1'b1;

   typedef struct packed {
      logic [KeyFields-1:0][31:0] group_key;
      logic [63:0]                time_bits;
      logic [31:0]                first_antenna;
      logic [31:0]                second_antenna;
      logic [47:0]                row_number;
      logic [AddrWidth-1:0]       load_order;
   } row_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic                 write_en;    // write wr_row at wr_addr
      logic [AddrWidth-1:0] wr_addr;
      logic                 wr_from_in;  // 1: input row, 0: last row copy
      logic                 rd_en;
      logic [AddrWidth-1:0] rd_addr;
      logic                 cmp_start;   // first row read of a scan
      logic                 cmp_take;    // compare read row against best
      logic [AddrWidth-1:0] cmp_index;   // slot of the row being compared
   } cmd_type;

   typedef struct packed {
      logic [AddrWidth-1:0] best_index;
      row_type              best_row;
      row_type              rd_row;
   } stat_type;

   // Signed 32-bit compare: -1, 0, +1 as less/equal/greater flags.
   function automatic logic [1:0] cmp_s32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      x = a ^ 32'h8000_0000;
      y = b ^ 32'h8000_0000;
      cmp_s32 = {x < y, x > y};
   endfunction

   // Double compare on bits, NaN largest and all NaNs equal, signed zeros equal.
   function automatic logic [1:0] cmp_time(input logic [63:0] a, input logic [63:0] b);
      logic        an;
      logic        bn;
      logic        az;
      logic        bz;
      logic [63:0] ka;
      logic [63:0] kb;
      an = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
      bn = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
      az = (a[62:0] == 63'd0);
      bz = (b[62:0] == 63'd0);
      ka = az ? 64'h8000_0000_0000_0000 : (a[63] ? ~a : (a | 64'h8000_0000_0000_0000));
      kb = bz ? 64'h8000_0000_0000_0000 : (b[63] ? ~b : (b | 64'h8000_0000_0000_0000));
      if (an || bn) begin
         cmp_time = (an && bn) ? 2'b00 : (an ? 2'b01 : 2'b10);
      end else begin
         cmp_time = {ka < kb, ka > kb};
      end
   endfunction

endpackage

[sv/cks_datapath.sv]
// ----------------------------------------------------------------------------
// cks_datapath: row memory and running minimum
// Holds rows in one memory, reads one row a cycle, keeps the best row so far.
// ----------------------------------------------------------------------------
module cks_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  cks_pkg::cmd_type            cmd,
   input  logic [cks_pkg::UsedWidth-1:0] keys_used,
   input  cks_pkg::row_type            in_row,
   output cks_pkg::stat_type           stat
);
   import cks_pkg::*;

   row_type              mem [MaxRows];
   row_type              rd_row_ff;
   row_type              best_row_ff;
   row_type              best_row_in;
   logic [AddrWidth-1:0] best_idx_ff;
   logic [AddrWidth-1:0] best_idx_in;
   logic [UsedWidth-1:0] used;
   logic                 rd_first;
   logic                 decided;
   logic [1:0]           c;
   integer               k;

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem[cmd.wr_addr] <= cmd.wr_from_in ? in_row : rd_row_ff;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= mem[cmd.rd_addr];
      end
   end

   // Clamp the key count to the fields present.
   assign used = (keys_used > UsedWidth'(MaxGroupKeys)) ? UsedWidth'(MaxGroupKeys) : keys_used;

   // Decide whether the read row pops before the best row.
   always_comb begin
      rd_first = 1'b0;
      decided  = 1'b0;
      c        = 2'b00;
      for (k = 0; k < KeyFields; k++) begin
         if (!decided && (UsedWidth'(k) < used)) begin
            c = cmp_s32(rd_row_ff.group_key[k], best_row_ff.group_key[k]);
            if (c != 2'b00) begin
               rd_first = c[1];
               decided  = 1'b1;
            end
         end
      end
      if (!decided) begin
         c = cmp_time(rd_row_ff.time_bits, best_row_ff.time_bits);
         if (c != 2'b00) begin
            rd_first = c[1];
            decided  = 1'b1;
         end
      end
      if (!decided) begin
         c = cmp_s32(rd_row_ff.first_antenna, best_row_ff.first_antenna);
         if (c != 2'b00) begin
            rd_first = c[1];
            decided  = 1'b1;
         end
      end
      if (!decided) begin
         c = cmp_s32(rd_row_ff.second_antenna, best_row_ff.second_antenna);
         if (c != 2'b00) begin
            rd_first = c[1];
            decided  = 1'b1;
         end
      end
      if (!decided) begin
         rd_first = rd_row_ff.load_order < best_row_ff.load_order;
      end
   end

   // Track the best row seen in this scan.
   always_comb begin
      best_row_in = best_row_ff;
      best_idx_in = best_idx_ff;
      if (cmd.cmp_start || (cmd.cmp_take && rd_first)) begin
         best_row_in = rd_row_ff;
         best_idx_in = cmd.cmp_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_idx_ff <= '0;
      end else begin
         best_idx_ff <= best_idx_in;
      end
      best_row_ff <= best_row_in;
   end

   assign stat.best_index = best_idx_ff;
   assign stat.best_row   = best_row_ff;
   assign stat.rd_row     = rd_row_ff;

endmodule

[sv/cks_ctrl.sv]
// ----------------------------------------------------------------------------
// cks_ctrl: sequencer of the row sorter
// Takes requests, runs the pop scan and the refill, and holds the response.
// ----------------------------------------------------------------------------
module cks_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last_row,
   output logic                         rsp_has_row,
   output cks_pkg::cmd_type             cmd,
   input  cks_pkg::stat_type            stat
);
   import cks_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_FIN   = 6'b000100,
      ST_RDL   = 6'b001000,
      ST_WRL   = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  drain_ff, drain_in;
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth-1:0]  cmp_ptr_ff, cmp_ptr_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  first_ff, first_in;
   logic [1:0]            status_ff, status_in;
   logic                  last_ff, last_in;
   logic                  hasrow_ff, hasrow_in;
   logic [CountWidth-1:0] last_slot;

   assign last_slot = count_ff - CountWidth'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drain_in   = drain_ff;
      rd_ptr_in  = rd_ptr_ff;
      cmp_ptr_in = cmp_ptr_ff;
      cmp_vld_in = 1'b0;
      first_in   = 1'b0;
      status_in  = status_ff;
      last_in    = last_ff;
      hasrow_in  = hasrow_ff;
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in   = 1'b0;
               hasrow_in = 1'b0;
               if (req_opcode == OpPush) begin
                  if (drain_ff || (count_ff >= CountWidth'(MaxRows))) begin
                     status_in = StatusPushRej;
                  end else begin
                     status_in      = StatusPushOk;
                     cmd.write_en   = 1'b1;
                     cmd.wr_from_in = 1'b1;
                     cmd.wr_addr    = count_ff[AddrWidth-1:0];
                     count_in       = count_ff + CountWidth'(1);
                  end
                  state_in = ST_RESP;
               end else if (count_ff == '0) begin
                  status_in = StatusPopEmpty;
                  state_in  = ST_RESP;
               end else begin
                  // start the scan: issue read of slot 0
                  drain_in    = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = '0;
                  rd_ptr_in   = AddrWidth'(1);
                  cmp_ptr_in  = '0;
                  cmp_vld_in  = 1'b1;
                  first_in    = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // compare the row read last cycle, issue the next read
            cmd.cmp_start = cmp_vld_ff && first_ff;
            cmd.cmp_take  = cmp_vld_ff && !first_ff;
            cmd.cmp_index = cmp_ptr_ff;
            cmp_ptr_in    = rd_ptr_ff;
            if (CountWidth'(rd_ptr_ff) < count_ff && !(rd_ptr_ff == '0 && !first_ff)) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = rd_ptr_ff;
               rd_ptr_in   = rd_ptr_ff + AddrWidth'(1);
               cmp_vld_in  = 1'b1;
               if (rd_ptr_ff == AddrWidth'(MaxRows - 1)) begin
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_FIN;
            end
            if (!(CountWidth'(rd_ptr_ff) < count_ff)) begin
               state_in = cmp_vld_ff ? ST_FIN : ST_RDL;
            end
         end
         ST_FIN: begin
            // last compare of the scan
            cmd.cmp_take  = cmp_vld_ff;
            cmd.cmp_index = cmp_ptr_ff;
            state_in      = ST_RDL;
         end
         ST_RDL: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = last_slot[AddrWidth-1:0];
            status_in   = StatusPopped;
            hasrow_in   = 1'b1;
            state_in    = ST_WRL;
         end
         ST_WRL: begin
            // move the last row into the hole, shrink the store
            cmd.write_en = 1'b1;
            cmd.wr_addr  = stat.best_index;
            count_in     = last_slot;
            if (last_slot == '0) begin
               drain_in = 1'b0;
               last_in  = 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         drain_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         first_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         drain_ff   <= drain_in;
         cmp_vld_ff <= cmp_vld_in;
         first_ff   <= first_in;
      end
      rd_ptr_ff  <= rd_ptr_in;
      cmp_ptr_ff <= cmp_ptr_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
      hasrow_ff  <= hasrow_in;
   end

   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_status   = status_ff;
   assign rsp_last_row = last_ff;
   assign rsp_has_row  = hasrow_ff;

endmodule

[sv/composite_key_row_sorter_top.sv]
// ----------------------------------------------------------------------------
// composite_key_row_sorter_top: multi-key row store with sorted pop
// Stores rows, pops the smallest by group keys, time, antenna 1, antenna 2.
// ----------------------------------------------------------------------------
// channel   direction  transfer on
// req_      in         req_valid & req_ready
// rsp_      out        rsp_valid & rsp_ready
// apb       in         psel & penable & pwrite & pready
//
// A push occupies the accept cycle and the response cycle.
// A pop scans every stored row through the single memory read port: the
// accept, a read of each stored row, a last compare, a read and a write of
// the last row, and the response.
// Reset is synchronous; no clearing pass. A stalled response holds the block.
// ----------------------------------------------------------------------------
module composite_key_row_sorter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic signed [31:0]  req_group_key_0,
   input  logic signed [31:0]  req_group_key_1,
   input  logic signed [31:0]  req_group_key_2,
   input  logic signed [31:0]  req_group_key_3,
   input  logic [63:0]         req_time_bits,
   input  logic signed [31:0]  req_first_antenna,
   input  logic signed [31:0]  req_second_antenna,
   input  logic [47:0]         req_row_number,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_out_group_key_0,
   output logic signed [31:0]  rsp_out_group_key_1,
   output logic signed [31:0]  rsp_out_group_key_2,
   output logic signed [31:0]  rsp_out_group_key_3,
   output logic [63:0]         rsp_out_time_bits,
   output logic signed [31:0]  rsp_out_first_antenna,
   output logic signed [31:0]  rsp_out_second_antenna,
   output logic [47:0]         rsp_out_row_number,
   output logic                rsp_last_row,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import cks_pkg::*;

   localparam logic [1:0] RegKeysUsed = 2'd0;

   logic [UsedWidth-1:0] keys_ff;
   cmd_type              cmd;
   stat_type             stat;
   row_type              in_row;
   logic                 has_row;

   assign pready = 1'b1;

   // Register write and read.
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else if (psel && penable && pwrite && paddr == RegKeysUsed) begin
         keys_ff <= pwdata[UsedWidth-1:0];
      end
   end
   assign prdata = (paddr == RegKeysUsed) ? {{(32-UsedWidth){1'b0}}, keys_ff} : 32'd0;

   always_comb begin
      in_row.group_key[0]   = req_group_key_0;
      in_row.group_key[1]   = req_group_key_1;
      in_row.group_key[2]   = req_group_key_2;
      in_row.group_key[3]   = req_group_key_3;
      in_row.time_bits      = req_time_bits;
      in_row.first_antenna  = req_first_antenna;
      in_row.second_antenna = req_second_antenna;
      in_row.row_number     = req_row_number;
      in_row.load_order     = cmd.wr_addr;
   end

   cks_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_last_row(rsp_last_row),
      .rsp_has_row (has_row),
      .cmd         (cmd),
      .stat        (stat)
   );

   cks_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .keys_used(keys_ff),
      .in_row   (in_row),
      .stat     (stat)
   );

   // Zero the row fields when no row was popped.
   always_comb begin
      rsp_out_group_key_0    = has_row ? stat.best_row.group_key[0] : '0;
      rsp_out_group_key_1    = has_row ? stat.best_row.group_key[1] : '0;
      rsp_out_group_key_2    = has_row ? stat.best_row.group_key[2] : '0;
      rsp_out_group_key_3    = has_row ? stat.best_row.group_key[3] : '0;
      rsp_out_time_bits      = has_row ? stat.best_row.time_bits : '0;
      rsp_out_first_antenna  = has_row ? stat.best_row.first_antenna : '0;
      rsp_out_second_antenna = has_row ? stat.best_row.second_antenna : '0;
      rsp_out_row_number     = has_row ? stat.best_row.row_number : '0;
   end

endmodule

[sv/cks_checker.sv]
// ----------------------------------------------------------------------------
// cks_checker: port-level checks of the row sorter
// Watches request and response handshakes over time.
// ----------------------------------------------------------------------------
module cks_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_last_row
);
   import cks_pkg::*;

   // No new request while a response waits.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready during response");

   // A response stays until transferred.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // Last row only on a popped row.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |-> rsp_status == StatusPopped)
      else $error("last row without pop");

   // Accepted request leads to no immediate ready.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");

endmodule

bind composite_key_row_sorter_top cks_checker u_cks_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_last_row(rsp_last_row)
);
